// ===== sv/prc_pkg.sv =====
// Shared types, codes and defaults for the page range permission checker.
package prc_pkg;

  // Default geometry, handed to the top level parameters.
  localparam int PAGE_SHIFT_DEF = 13;
  localparam int REGION_PAGES_DEF = 128;

  // Table-write beats carry a 7-bit index, so no more entries can ever be loaded.
  localparam int INDEX_W = 7;
  localparam int MAX_TABLE = 1 << INDEX_W;

  // Request actions.
  localparam logic [1:0] ACT_WR_KERNEL = 2'd0;
  localparam logic [1:0] ACT_WR_USER   = 2'd1;
  localparam logic [1:0] ACT_CHECK     = 2'd2;

  // Fault reasons reported with each check result.
  localparam logic [2:0] FAULT_NONE    = 3'd0;
  localparam logic [2:0] FAULT_OUTSIDE = 3'd1;
  localparam logic [2:0] FAULT_KERNEL  = 3'd2;
  localparam logic [2:0] FAULT_INVALID = 3'd3;
  localparam logic [2:0] FAULT_PERM    = 3'd4;

  // One request beat.
  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        address;
    logic [31:0]        length;
    logic               need_read;
    logic               need_write;
    logic               need_exec;
    logic               kernel_allowed;
    logic [INDEX_W-1:0] entry_index;
    logic               entry_valid;
    logic [2:0]         entry_prot;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic       access_ok;
    logic [2:0] fault_reason;
  } rsp_t;

  // One page table entry: prot bit0 read, bit1 write, bit2 exec.
  typedef struct packed {
    logic       valid;
    logic [2:0] prot;
  } entry_t;

  // Range classification handed from the decoder to the walk control.
  typedef struct packed {
    logic       done;
    logic [2:0] reason;
    logic       region;
  } range_t;

endpackage

// ===== sv/prc_decode.sv =====
// Range decoder: bounds, region and kernel tests, and the first and last page of a range.
module prc_decode #(
  parameter int PAGE_SHIFT = prc_pkg::PAGE_SHIFT_DEF,
  parameter int REGION_PAGES = prc_pkg::REGION_PAGES_DEF,
  localparam int PAGE_W = $clog2(REGION_PAGES)
) (
  input  logic [31:0]       address,
  input  logic [31:0]       length,
  input  logic              kernel_allowed,
  output prc_pkg::range_t   range,
  output logic [PAGE_W-1:0] first_page,
  output logic [PAGE_W-1:0] last_page
);

  localparam logic [32:0] REGION = 33'(REGION_PAGES) << PAGE_SHIFT;
  localparam logic [32:0] TOP = REGION << 1;

  logic [32:0] addr_x;
  logic [32:0] last_x;
  logic [32:0] first_off;
  logic [32:0] last_off;

  // Classify the range; a range that needs no table walk is marked done.
  always_comb begin
    addr_x = {1'b0, address};
    last_x = addr_x + {1'b0, length} - 33'd1;
    range.done = 1'b1;
    range.reason = prc_pkg::FAULT_NONE;
    range.region = (addr_x >= REGION);
    if (addr_x >= TOP) begin
      range.reason = prc_pkg::FAULT_OUTSIDE;
    end else if (length == 32'd0) begin
      range.reason = prc_pkg::FAULT_NONE;
    end else if (last_x >= TOP) begin
      range.reason = prc_pkg::FAULT_OUTSIDE;
    end else if (!range.region) begin
      if (last_x >= REGION) begin
        range.reason = prc_pkg::FAULT_OUTSIDE;
      end else if (!kernel_allowed) begin
        range.reason = prc_pkg::FAULT_KERNEL;
      end else begin
        range.done = 1'b0;
      end
    end else begin
      range.done = 1'b0;
    end
    first_off = range.region ? addr_x - REGION : addr_x;
    last_off = range.region ? last_x - REGION : last_x;
  end

  // Page numbers within the region; only meaningful when a walk follows.
  assign first_page = PAGE_W'(first_off >> PAGE_SHIFT);
  assign last_page = PAGE_W'(last_off >> PAGE_SHIFT);

endmodule

// ===== sv/prc_table.sv =====
// Page table memory: both regions in one synchronous RAM with per-entry written flags.
module prc_table #(
  parameter int REGION_PAGES = prc_pkg::REGION_PAGES_DEF,
  localparam int PAGE_W = $clog2(REGION_PAGES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic                        wr_region,
  input  logic [prc_pkg::INDEX_W-1:0] wr_index,
  input  prc_pkg::entry_t             wr_entry,
  input  logic                        rd_en,
  input  logic                        rd_region,
  input  logic [PAGE_W-1:0]           rd_page,
  output prc_pkg::entry_t             rd_entry
);

  // Only the pages a write beat can reach are stored; the rest always read invalid.
  localparam int DEPTH = (REGION_PAGES < prc_pkg::MAX_TABLE) ? REGION_PAGES : prc_pkg::MAX_TABLE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOTS = 2 << ADDR_W;

  prc_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] written;
  prc_pkg::entry_t rd_q;
  logic rd_live;

  logic wr_hit;
  logic rd_hit;
  logic [ADDR_W:0] wr_addr;
  logic [ADDR_W:0] rd_addr;

  assign wr_hit = wr_en && (32'(wr_index) < 32'(DEPTH));
  assign wr_addr = {wr_region, wr_index[ADDR_W-1:0]};
  assign rd_hit = (32'(rd_page) < 32'(DEPTH));
  assign rd_addr = {rd_region, rd_page[ADDR_W-1:0]};

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Written flags stand in for the reset value of entries never loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_live <= 1'b0;
    end else begin
      if (wr_hit) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= rd_hit && written[rd_addr];
      end
    end
  end

  assign rd_entry = rd_live ? rd_q : '0;

endmodule

// ===== sv/page_range_permission_check.sv =====
// Top level of the page range permission checker: request handling, page walk, result register.
//
//   channel  direction  handshake               beat
//   req      in         req_valid / req_stall   prc_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall   prc_pkg::rsp_t
//
// A table-write beat never stalls the request side; req_stall stays low for the next beat.
// A check beat is decoded first and, unless the decode settles it, walks the pages up to
// the first failing page or the last page; the single read port of the table RAM reads one
// page a cycle and each entry is judged the cycle after its read.
// Reset clears the written flags at once, so there is no clearing pass.
// A result waits in the rsp register while stalled; table writes are still taken meanwhile.
module page_range_permission_check #(
  parameter int PAGE_SHIFT = prc_pkg::PAGE_SHIFT_DEF,
  parameter int REGION_PAGES = prc_pkg::REGION_PAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  prc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output prc_pkg::rsp_t rsp
);

  localparam int PAGE_W = $clog2(REGION_PAGES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  prc_pkg::req_t req_q;
  logic req_acc;
  logic [2:0] need;

  prc_pkg::range_t range_d;
  logic [PAGE_W-1:0] first_d;
  logic [PAGE_W-1:0] last_d;

  logic [PAGE_W-1:0] page_cur;
  logic [PAGE_W-1:0] page_last;
  logic region_q;
  logic issue_more;
  logic pend;
  logic pend_last;

  logic tbl_wr_en;
  logic rd_en;
  prc_pkg::entry_t rd_entry;

  logic fin;
  logic [2:0] fin_reason;
  logic [2:0] reason_q;
  logic out_free;
  logic load;

  // Request side: one check at a time.
  assign req_stall = (state != ST_IDLE);
  assign req_acc = req_valid && !req_stall;
  assign tbl_wr_en = req_acc && (req.action inside {prc_pkg::ACT_WR_KERNEL, prc_pkg::ACT_WR_USER});
  assign need = {req_q.need_exec, req_q.need_write, req_q.need_read};

  // Capture a check beat for decoding.
  always_ff @(posedge clk) begin
    if (req_acc && (req.action == prc_pkg::ACT_CHECK)) begin
      req_q <= req;
    end
  end

  prc_decode #(
    .PAGE_SHIFT  (PAGE_SHIFT),
    .REGION_PAGES(REGION_PAGES)
  ) u_decode (
    .address       (req_q.address),
    .length        (req_q.length),
    .kernel_allowed(req_q.kernel_allowed),
    .range         (range_d),
    .first_page    (first_d),
    .last_page     (last_d)
  );

  prc_table #(
    .REGION_PAGES(REGION_PAGES)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (tbl_wr_en),
    .wr_region(req.action == prc_pkg::ACT_WR_USER),
    .wr_index (req.entry_index),
    .wr_entry ({req.entry_valid, req.entry_prot}),
    .rd_en    (rd_en),
    .rd_region(region_q),
    .rd_page  (page_cur),
    .rd_entry (rd_entry)
  );

  // Reads are issued back to back; each entry is judged the cycle after its read.
  assign rd_en = (state == ST_WALK) && issue_more;

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_more <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
      if (state == ST_DECODE) begin
        issue_more <= !range_d.done;
      end else if (rd_en) begin
        issue_more <= (page_cur != page_last);
      end
    end
  end

  // Walk position.
  always_ff @(posedge clk) begin
    if (state == ST_DECODE) begin
      page_cur <= first_d;
      page_last <= last_d;
      region_q <= range_d.region;
    end else if (rd_en) begin
      page_cur <= page_cur + PAGE_W'(1);
      pend_last <= (page_cur == page_last);
    end
  end

  // Finish detection: early decode result, failing page, last page passed, or held result.
  always_comb begin
    fin = 1'b0;
    fin_reason = prc_pkg::FAULT_NONE;
    case (state)
      ST_DECODE: begin
        fin = range_d.done;
        fin_reason = range_d.reason;
      end
      ST_WALK: begin
        if (pend) begin
          if (!rd_entry.valid) begin
            fin = 1'b1;
            fin_reason = prc_pkg::FAULT_INVALID;
          end else if ((need & ~rd_entry.prot) != 3'd0) begin
            fin = 1'b1;
            fin_reason = prc_pkg::FAULT_PERM;
          end else if (pend_last) begin
            fin = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        fin = 1'b1;
        fin_reason = reason_q;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign load = fin && out_free;

  // Control sequence.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc && (req.action == prc_pkg::ACT_CHECK)) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (range_d.done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end else begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (fin) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Reason kept while the result register is still occupied.
  always_ff @(posedge clk) begin
    if (fin) begin
      reason_q <= fin_reason;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.access_ok <= (fin_reason == prc_pkg::FAULT_NONE);
      rsp.fault_reason <= fin_reason;
    end
  end

endmodule

// ===== sv/prc_checker.sv =====
// Port checker for the page range permission checker, bound to the top level.
module prc_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input prc_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input prc_pkg::rsp_t rsp
);

  // A stalled result beat stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result beat changed while stalled");

  // The pass flag agrees with the fault reason.
  a_ok_reason: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.access_ok == (rsp.fault_reason == prc_pkg::FAULT_NONE)))
    else $error("access_ok disagrees with fault_reason");

  // Only defined fault reasons are reported.
  a_reason_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.fault_reason == prc_pkg::FAULT_NONE ||
                   rsp.fault_reason == prc_pkg::FAULT_OUTSIDE ||
                   rsp.fault_reason == prc_pkg::FAULT_KERNEL ||
                   rsp.fault_reason == prc_pkg::FAULT_INVALID ||
                   rsp.fault_reason == prc_pkg::FAULT_PERM))
    else $error("undefined fault reason");

  // A check beat holds off the next request while it is worked on.
  a_check_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.action == prc_pkg::ACT_CHECK) |=> req_stall)
    else $error("request taken during a check");

  // A new result appears only at the end of a check.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without a check in progress");

endmodule

bind page_range_permission_check prc_checker u_prc_checker (.*);

// ===== dv/page_range_permission_check_tb.sv =====
// Testbench for the page range permission checker: a directed table, then random traffic.
`timescale 1ns / 1ps
module page_range_permission_check_tb;

  localparam int PAGE_SHIFT = prc_pkg::PAGE_SHIFT_DEF;
  localparam int REGION_PAGES = prc_pkg::REGION_PAGES_DEF;
  localparam logic [63:0] REGION_BYTES = 64'(REGION_PAGES) << PAGE_SHIFT;
  localparam logic [63:0] TOP_BYTES = REGION_BYTES * 2;
  localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_SHIFT;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Permission masks: bit0 read, bit1 write, bit2 exec.
  localparam logic [2:0] PERM_NONE = 3'b000;
  localparam logic [2:0] PERM_R = 3'b001;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b100;
  localparam logic [2:0] PERM_RWX = 3'b111;

  // Results that can be read straight off the rules.
  localparam prc_pkg::rsp_t RSP_OK = {1'b1, prc_pkg::FAULT_NONE};
  localparam prc_pkg::rsp_t RSP_OUTSIDE = {1'b0, prc_pkg::FAULT_OUTSIDE};
  localparam prc_pkg::rsp_t RSP_KERNEL = {1'b0, prc_pkg::FAULT_KERNEL};
  localparam prc_pkg::rsp_t RSP_INVALID = {1'b0, prc_pkg::FAULT_INVALID};

  localparam int RANDOM_BEATS = 1200;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    prc_pkg::req_t beat;
    bit            typed;
    prc_pkg::rsp_t result;
  } stim_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  prc_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  prc_pkg::rsp_t rsp;

  prc_pkg::entry_t kernel_pages [REGION_PAGES];
  prc_pkg::entry_t user_pages [REGION_PAGES];
  prc_pkg::rsp_t pending_results [$];
  stim_row_t plan [$];

  bit failed = 1'b0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [9:0] stall_cycle = '0;

  page_range_permission_check #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .REGION_PAGES(REGION_PAGES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walks pages first_pg..last_pg of one table and returns the first fault found.
  function automatic logic [2:0] page_walk_fault(logic user, logic [63:0] first_pg,
                                                 logic [63:0] last_pg, logic [2:0] need);
    logic [63:0] pg;
    prc_pkg::entry_t e;
    for (pg = first_pg; pg <= last_pg; pg++) begin
      if (pg >= REGION_PAGES) return prc_pkg::FAULT_OUTSIDE;
      e = user ? user_pages[pg] : kernel_pages[pg];
      if (!e.valid) return prc_pkg::FAULT_INVALID;
      if ((need & ~e.prot) != PERM_NONE) return prc_pkg::FAULT_PERM;
    end
    return prc_pkg::FAULT_NONE;
  endfunction

  // Fault reason of one check beat against the current tables.
  function automatic logic [2:0] range_fault(prc_pkg::req_t b);
    logic [63:0] first_b;
    logic [63:0] last_b;
    logic [2:0] need;
    first_b = {32'b0, b.address};
    need = {b.need_exec, b.need_write, b.need_read};
    if (first_b >= TOP_BYTES) return prc_pkg::FAULT_OUTSIDE;
    if (b.length == 32'd0) return prc_pkg::FAULT_NONE;
    last_b = first_b + {32'b0, b.length} - 64'd1;
    if (last_b >= TOP_BYTES) return prc_pkg::FAULT_OUTSIDE;
    if (first_b < REGION_BYTES) begin
      if (last_b >= REGION_BYTES) return prc_pkg::FAULT_OUTSIDE;
      if (!b.kernel_allowed) return prc_pkg::FAULT_KERNEL;
      return page_walk_fault(1'b0, first_b >> PAGE_SHIFT, last_b >> PAGE_SHIFT, need);
    end
    return page_walk_fault(1'b1, (first_b - REGION_BYTES) >> PAGE_SHIFT,
                           (last_b - REGION_BYTES) >> PAGE_SHIFT, need);
  endfunction

  function automatic prc_pkg::req_t check_beat(logic [31:0] addr, logic [31:0] len,
                                               logic [2:0] need, logic kern);
    prc_pkg::req_t b;
    b = '0;
    b.action = prc_pkg::ACT_CHECK;
    b.address = addr;
    b.length = len;
    {b.need_exec, b.need_write, b.need_read} = need;
    b.kernel_allowed = kern;
    return b;
  endfunction

  function automatic prc_pkg::req_t table_beat(logic [1:0] act,
                                               logic [prc_pkg::INDEX_W-1:0] idx,
                                               logic valid, logic [2:0] prot);
    prc_pkg::req_t b;
    b = '0;
    b.action = act;
    b.entry_index = idx;
    b.entry_valid = valid;
    b.entry_prot = prot;
    return b;
  endfunction

  // Random beat: mostly table loads and well-formed ranges, with some noise.
  function automatic prc_pkg::req_t random_beat();
    prc_pkg::req_t b;
    int unsigned pick;
    logic [63:0] base;
    logic [63:0] border;
    b.action = prc_pkg::ACT_CHECK;
    b.address = $urandom;
    b.length = $urandom;
    {b.need_read, b.need_write, b.need_exec, b.kernel_allowed, b.entry_valid} = 5'($urandom);
    b.entry_index = prc_pkg::INDEX_W'($urandom);
    b.entry_prot = 3'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      // Table loads, biased toward valid entries with full rights so walks get deep.
      b.action = pick[0] ? prc_pkg::ACT_WR_USER : prc_pkg::ACT_WR_KERNEL;
      b.entry_valid = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 2) != 0) b.entry_prot = PERM_RWX;
    end else if (pick < 32) begin
      b.action = ACT_UNUSED;
    end else if (pick < 85) begin
      // A range starting in one region, mostly kept inside it and mostly up to three pages long.
      base = ($urandom_range(0, 1) == 1) ? REGION_BYTES : 64'd0;
      b.address = 32'(base + ($urandom % REGION_BYTES));
      case ($urandom_range(0, 19))
        0: b.length = 32'd0;
        1: b.length = $urandom_range(1, 32'(REGION_BYTES));
        default: b.length = $urandom_range(1, 3 * PAGE_BYTES);
      endcase
      if ($urandom_range(0, 4) != 0 &&
          {32'b0, b.address} - base + {32'b0, b.length} > REGION_BYTES) begin
        b.length = 32'(base + REGION_BYTES - {32'b0, b.address});
      end
      b.kernel_allowed = ($urandom_range(0, 9) != 0);
    end else if (pick < 93) begin
      // Ranges grazing the region boundary or the top of user space.
      border = ($urandom_range(0, 1) == 1) ? REGION_BYTES : TOP_BYTES;
      b.address = 32'(border - {32'b0, $urandom_range(0, 2 * PAGE_BYTES)});
      b.length = $urandom_range(0, 3 * PAGE_BYTES);
    end
    return b;
  endfunction

  // Applies an accepted beat to the table copies or queues its expected result.
  task automatic take_beat(prc_pkg::req_t b, bit typed, prc_pkg::rsp_t typed_result);
    logic [2:0] fault;
    case (b.action)
      prc_pkg::ACT_WR_KERNEL: begin
        if (b.entry_index < REGION_PAGES)
          kernel_pages[b.entry_index] = {b.entry_valid, b.entry_prot};
      end
      prc_pkg::ACT_WR_USER: begin
        if (b.entry_index < REGION_PAGES)
          user_pages[b.entry_index] = {b.entry_valid, b.entry_prot};
      end
      prc_pkg::ACT_CHECK: begin
        fault = range_fault(b);
        if (typed) pending_results.push_back(typed_result);
        else pending_results.push_back({fault == prc_pkg::FAULT_NONE, fault});
      end
      default: ;
    endcase
  endtask

  // Sends one beat in bursts with random gaps, then waits for it to be taken.
  task automatic send_beat(prc_pkg::req_t b, bit typed, prc_pkg::rsp_t typed_result);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= b;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    take_beat(b, typed, typed_result);
  endtask

  // Result-side stall pattern: quiet, coin-flip, long runs and light stalls in turn.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= ($urandom_range(0, 1) == 1);
      2'd2: rsp_stall <= (stall_cycle[3:0] < 4'd9);
      default: rsp_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    prc_pkg::rsp_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          failed = 1'b1;
          $display("%0t: unexpected result beat, actual access_ok %0d fault_reason %0d",
                   $time, rsp.access_ok, rsp.fault_reason);
        end else begin
          want = pending_results.pop_front();
          if (rsp.access_ok !== want.access_ok) begin
            failed = 1'b1;
            $display("%0t: access_ok expected %0d actual %0d",
                     $time, want.access_ok, rsp.access_ok);
          end
          if (rsp.fault_reason !== want.fault_reason) begin
            failed = 1'b1;
            $display("%0t: fault_reason expected %0d actual %0d",
                     $time, want.fault_reason, rsp.fault_reason);
          end
        end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: reset, directed table, random traffic, drain.
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    foreach (kernel_pages[i]) kernel_pages[i] = '0;
    foreach (user_pages[i]) user_pages[i] = '0;

    // Empty tables, the address tests and the kernel refusal.
    plan.push_back('{check_beat(32'd0, 32'd1, PERM_R, 1'b1), 1'b1, RSP_INVALID});
    plan.push_back('{check_beat(32'(REGION_BYTES), 32'd1, PERM_R, 1'b0), 1'b1, RSP_INVALID});
    plan.push_back('{check_beat(32'(TOP_BYTES), 32'd0, PERM_NONE, 1'b1), 1'b1, RSP_OUTSIDE});
    plan.push_back('{check_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, PERM_RWX, 1'b1),
                     1'b1, RSP_OUTSIDE});
    plan.push_back('{check_beat(32'h100, 32'd0, PERM_RWX, 1'b0), 1'b1, RSP_OK});
    plan.push_back('{check_beat(32'(TOP_BYTES - 1), 32'd2, PERM_R, 1'b1), 1'b1, RSP_OUTSIDE});
    plan.push_back('{check_beat(32'(REGION_BYTES - 1), 32'd2, PERM_R, 1'b1),
                     1'b1, RSP_OUTSIDE});
    plan.push_back('{check_beat(32'(REGION_BYTES - 1), 32'd2, PERM_R, 1'b0),
                     1'b1, RSP_OUTSIDE});
    plan.push_back('{check_beat(32'd0, 32'd1, PERM_R, 1'b0), 1'b1, RSP_KERNEL});
    plan.push_back('{check_beat(32'd0, 32'hFFFF_FFFF, PERM_NONE, 1'b1), 1'b1, RSP_OUTSIDE});
    // Load both ends of both tables, then an action that must be ignored.
    plan.push_back('{table_beat(prc_pkg::ACT_WR_KERNEL, 7'd0, 1'b1, PERM_RWX), 1'b0, RSP_OK});
    plan.push_back('{table_beat(prc_pkg::ACT_WR_KERNEL, 7'd1, 1'b1, PERM_R), 1'b0, RSP_OK});
    plan.push_back('{table_beat(prc_pkg::ACT_WR_KERNEL, 7'd127, 1'b1, PERM_RWX), 1'b0, RSP_OK});
    plan.push_back('{table_beat(prc_pkg::ACT_WR_USER, 7'd0, 1'b1, PERM_RWX), 1'b0, RSP_OK});
    plan.push_back('{table_beat(prc_pkg::ACT_WR_USER, 7'd1, 1'b0, PERM_RWX), 1'b0, RSP_OK});
    plan.push_back('{table_beat(prc_pkg::ACT_WR_USER, 7'd127, 1'b1, PERM_W | PERM_X),
                     1'b0, RSP_OK});
    plan.push_back('{table_beat(ACT_UNUSED, 7'd2, 1'b1, PERM_RWX), 1'b0, RSP_OK});
    // Walks over the loaded pages, checked by prediction, and a zero-length check with a fixed result.
    plan.push_back('{check_beat(32'd0, PAGE_BYTES, PERM_RWX, 1'b1), 1'b0, RSP_OK});
    plan.push_back('{check_beat(PAGE_BYTES - 1, 32'd2, PERM_W, 1'b1), 1'b0, RSP_OK});
    plan.push_back('{check_beat(32'(REGION_BYTES), 2 * PAGE_BYTES, PERM_R, 1'b0), 1'b0, RSP_OK});
    plan.push_back('{check_beat(32'(TOP_BYTES) - PAGE_BYTES, PAGE_BYTES, PERM_W | PERM_X, 1'b0),
                     1'b0, RSP_OK});
    plan.push_back('{check_beat(32'd0, 32'(REGION_BYTES), PERM_NONE, 1'b1), 1'b0, RSP_OK});
    plan.push_back('{check_beat(32'(REGION_BYTES) + PAGE_BYTES + 32'd5, 32'd0, PERM_RWX, 1'b0),
                     1'b1, RSP_OK});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].typed, plan[i].result);
    repeat (RANDOM_BEATS) send_beat(random_beat(), 1'b0, RSP_OK);
    req_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
